>>> rtl/heading_velocity_resolver_core_assert.svh
// Assertion macros for the heading velocity resolver RTL.
`ifndef HEADING_VELOCITY_RESOLVER_CORE_ASSERT_SVH
`define HEADING_VELOCITY_RESOLVER_CORE_ASSERT_SVH

// Check a condition at every clock edge outside reset.
`define HVR_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Check that a condition implies another one on the next clock edge.
`define HVR_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/hvr_pkg.sv
// Shared constants, tables and types of the heading velocity resolver.
`timescale 1ns / 1ps
`default_nettype none

package hvr_pkg;

    // Item field widths
    localparam int DATA_WIDTH = 16;
    localparam int HEADING_W  = 16;

    // CORDIC depth and arctangent table
    localparam int CORDIC_STAGES = 16;
    localparam int TABLE_LEN     = 24;
    localparam int USED_STAGES   = (CORDIC_STAGES < TABLE_LEN) ? CORDIC_STAGES : TABLE_LEN;
    localparam int IDX_W         = $clog2(TABLE_LEN);

    // Angle scaling: 1/64 degree units, accumulator in 2^-22 degree
    localparam int ANGLE_FRAC   = 16;
    localparam int FULL_TURN    = 23040;
    localparam int HALF_TURN    = 11520;
    localparam int QUARTER_TURN = 5760;

    // Reduced heading fits +/-5760; accumulator and vector widths
    localparam int A_W  = 14;
    localparam int Z_W  = 32;
    localparam int XY_W = DATA_WIDTH + 18;

    // Inverse CORDIC gain in Q30 and start rounding
    localparam longint INV_GAIN_Q30 = 652032874;
    localparam int     INV_W        = 31;
    localparam int     PRE_SHIFT    = 14;
    localparam int     PROD_W       = XY_W + PRE_SHIFT;

    // atan(2^-i) in degrees times 2^22
    localparam logic signed [Z_W-1:0] ATAN_LUT [0:TABLE_LEN-1] = '{
        32'sd188743680, 32'sd111421900, 32'sd58872272, 32'sd29884485,
        32'sd15000234,  32'sd7507429,   32'sd3754936,  32'sd1877430,
        32'sd938729,    32'sd469366,    32'sd234683,   32'sd117342,
        32'sd58671,     32'sd29335,     32'sd14668,    32'sd7334,
        32'sd3667,      32'sd1833,      32'sd917,      32'sd458,
        32'sd229,       32'sd115,       32'sd57,       32'sd29
    };

    // Rotation state carried from stage to stage
    typedef struct packed {
        logic                   negate;
        logic signed [XY_W-1:0] x;
        logic signed [XY_W-1:0] y;
        logic signed [Z_W-1:0]  z;
    } cordic_t;

endpackage

`default_nettype wire

>>> rtl/hvr_cmd_if.sv
// Input channel: direction, speed and heading of one item.
`timescale 1ns / 1ps
`default_nettype none

interface hvr_cmd_if;
    import hvr_pkg::*;

    logic                         valid;
    logic                         ready;
    logic                         direction_forward;
    logic signed [DATA_WIDTH-1:0] speed;
    logic signed [HEADING_W-1:0]  heading;

    modport source (output valid, output direction_forward, output speed, output heading,
                    input ready);
    modport sink (input valid, input direction_forward, input speed, input heading,
                  output ready);
endinterface

`default_nettype wire

>>> rtl/hvr_vel_if.sv
// Output channel: x and y velocity components of one item.
`timescale 1ns / 1ps
`default_nettype none

interface hvr_vel_if;
    import hvr_pkg::*;

    logic                         valid;
    logic                         ready;
    logic signed [DATA_WIDTH-1:0] x_component;
    logic signed [DATA_WIDTH-1:0] y_component;

    modport source (output valid, output x_component, output y_component, input ready);
    modport sink (input valid, input x_component, input y_component, output ready);
endinterface

`default_nettype wire

>>> rtl/hvr_prep.sv
// Front stages: heading reduction, then gain-compensated start vector.
`timescale 1ns / 1ps
`default_nettype none
`include "heading_velocity_resolver_core_assert.svh"

module hvr_prep (
    input  wire logic            clk,
    input  wire logic            rst_n,
    hvr_cmd_if.sink              cmd,
    output logic                 out_valid,
    input  wire logic            out_ready,
    output hvr_pkg::cordic_t     out_data
);
    import hvr_pkg::*;

    localparam int ANG_W = HEADING_W + 1;
    localparam logic signed [ANG_W-1:0] FULL_A    = ANG_W'(FULL_TURN);
    localparam logic signed [ANG_W-1:0] HALF_A    = ANG_W'(HALF_TURN);
    localparam logic signed [ANG_W-1:0] QUARTER_A = ANG_W'(QUARTER_TURN);
    localparam logic signed [INV_W-1:0] INV_A     = INV_W'(INV_GAIN_Q30);
    localparam logic signed [PROD_W-1:0] PRE_RND  = PROD_W'(1 << (PRE_SHIFT - 1));

    // Stage A registers
    logic                         a_valid_reg, a_valid_next;
    logic signed [A_W-1:0]        a_angle_reg;
    logic                         a_negate_reg;
    logic signed [DATA_WIDTH-1:0] a_speed_reg;
    logic                         a_ready;

    // Stage B registers
    logic                         b_valid_reg, b_valid_next;
    cordic_t                      b_reg;
    logic                         b_ready;

    // Reduction datapath
    logic signed [ANG_W-1:0]      h_ext;
    logic signed [ANG_W-1:0]      h_mod;
    logic signed [ANG_W-1:0]      h_half;
    logic signed [ANG_W-1:0]      h_quarter;
    logic                         h_flip;

    // Start vector datapath
    logic signed [PROD_W-1:0]     prod;
    logic signed [PROD_W-1:0]     prod_rnd;
    cordic_t                      b_next;

    assign b_ready   = !b_valid_reg || out_ready;
    assign a_ready   = !a_valid_reg || b_ready;
    assign cmd.ready = a_ready;

    // Fold the heading into +/-90 degrees, flipping the sign past it
    always_comb
    begin
        h_ext = ANG_W'(cmd.heading);
        if (h_ext < -FULL_A)
        begin
            h_mod = h_ext + FULL_A + FULL_A;
        end
        else if (h_ext < 0)
        begin
            h_mod = h_ext + FULL_A;
        end
        else if (h_ext >= FULL_A)
        begin
            h_mod = h_ext - FULL_A;
        end
        else
        begin
            h_mod = h_ext;
        end

        h_half = (h_mod >= HALF_A) ? h_mod - FULL_A : h_mod;

        h_flip = 1'b0;
        if (h_half > QUARTER_A)
        begin
            h_quarter = h_half - HALF_A;
            h_flip    = 1'b1;
        end
        else if (h_half < -QUARTER_A)
        begin
            h_quarter = h_half + HALF_A;
            h_flip    = 1'b1;
        end
        else
        begin
            h_quarter = h_half;
        end
    end

    // Scale the speed by the inverse gain and place the angle
    always_comb
    begin
        prod     = PROD_W'(a_speed_reg) * PROD_W'(INV_A);
        prod_rnd = prod + PRE_RND;
        b_next.negate = a_negate_reg;
        b_next.x      = prod_rnd[PROD_W-1:PRE_SHIFT];
        b_next.y      = '0;
        b_next.z      = {{(Z_W - A_W - ANGLE_FRAC){a_angle_reg[A_W-1]}}, a_angle_reg,
                         {ANGLE_FRAC{1'b0}}};
    end

    assign a_valid_next = a_ready ? cmd.valid : a_valid_reg;
    assign b_valid_next = b_ready ? a_valid_reg : b_valid_reg;

    // Advance the valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end
        else
        begin
            a_valid_reg <= a_valid_next;
            b_valid_reg <= b_valid_next;
        end
    end

    // Load the payloads when each stage moves
    always_ff @(posedge clk)
    begin
        if (cmd.valid && a_ready)
        begin
            a_angle_reg  <= h_quarter[A_W-1:0];
            a_negate_reg <= !cmd.direction_forward ^ h_flip;
            a_speed_reg  <= cmd.speed;
        end
        if (a_valid_reg && b_ready)
        begin
            b_reg <= b_next;
        end
    end

    assign out_valid = b_valid_reg;
    assign out_data  = b_reg;

    `HVR_ASSERT_ALWAYS(a_angle_range, !a_valid_reg || (a_angle_reg <= A_W'(QUARTER_TURN) && a_angle_reg >= -A_W'(QUARTER_TURN)), "reduced heading out of range")
    `HVR_ASSERT_ALWAYS(a_empty_takes, a_valid_reg || cmd.ready, "empty entry stage refused an item")
    `HVR_ASSERT_NEXT(b_stall_hold, b_valid_reg && !out_ready, b_valid_reg && $stable(b_reg), "start vector changed while stalled")
    `HVR_ASSERT_ALWAYS(b_y_zero, !b_valid_reg || b_reg.y == '0, "start vector y not zero")

endmodule

`default_nettype wire

>>> rtl/hvr_cordic_stage.sv
// One rotation step of the CORDIC with its own valid bit and register.
`timescale 1ns / 1ps
`default_nettype none

module hvr_cordic_stage (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic [hvr_pkg::IDX_W-1:0] stage_idx,
    input  wire logic                    in_valid,
    output logic                         in_ready,
    input  wire hvr_pkg::cordic_t        in_data,
    output logic                         out_valid,
    input  wire logic                    out_ready,
    output hvr_pkg::cordic_t             out_data
);
    import hvr_pkg::*;

    logic                   valid_reg, valid_next;
    cordic_t                data_reg, data_next;
    logic signed [XY_W-1:0] dx, dy;

    assign in_ready = !valid_reg || out_ready;

    // Rotate toward zero residual angle
    always_comb
    begin
        dx = in_data.y >>> stage_idx;
        dy = in_data.x >>> stage_idx;
        data_next.negate = in_data.negate;
        if (!in_data.z[Z_W-1])
        begin
            data_next.x = in_data.x - dx;
            data_next.y = in_data.y + dy;
            data_next.z = in_data.z - ATAN_LUT[stage_idx];
        end
        else
        begin
            data_next.x = in_data.x + dx;
            data_next.y = in_data.y - dy;
            data_next.z = in_data.z + ATAN_LUT[stage_idx];
        end
    end

    assign valid_next = in_ready ? in_valid : valid_reg;

    // Advance the valid bit
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Load the item when the stage moves
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

`default_nettype wire

>>> rtl/hvr_finish.sv
// Output stage: sign, round to Q8.8, saturate and hold the result item.
`timescale 1ns / 1ps
`default_nettype none

module hvr_finish (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    output logic                  in_ready,
    input  wire hvr_pkg::cordic_t in_data,
    hvr_vel_if.source             vel
);
    import hvr_pkg::*;

    localparam int SH_W = XY_W + 1 - ANGLE_FRAC;
    localparam logic signed [DATA_WIDTH-1:0] OUT_MAX = {1'b0, {(DATA_WIDTH-1){1'b1}}};
    localparam logic signed [DATA_WIDTH-1:0] OUT_MIN = {1'b1, {(DATA_WIDTH-1){1'b0}}};
    localparam logic signed [XY_W:0]         RND     = (XY_W+1)'(1 << (ANGLE_FRAC - 1));

    logic                         valid_reg, valid_next;
    logic signed [DATA_WIDTH-1:0] x_reg, y_reg;
    logic signed [DATA_WIDTH-1:0] x_next, y_next;

    function automatic logic signed [DATA_WIDTH-1:0] finish_value(
        input logic signed [XY_W-1:0] v,
        input logic                   neg
    );
        logic signed [XY_W:0]   ext;
        logic signed [XY_W:0]   sgn;
        logic signed [XY_W:0]   rnd;
        logic signed [SH_W-1:0] sh;
        ext = {v[XY_W-1], v};
        sgn = neg ? -ext : ext;
        rnd = sgn + RND;
        sh  = rnd[XY_W:ANGLE_FRAC];
        if (sh > SH_W'(OUT_MAX))
        begin
            return OUT_MAX;
        end
        else if (sh < SH_W'(OUT_MIN))
        begin
            return OUT_MIN;
        end
        return sh[DATA_WIDTH-1:0];
    endfunction

    assign in_ready = !valid_reg || vel.ready;

    // Sine (CORDIC y) lands in x_component, cosine (CORDIC x) in y_component
    assign x_next     = finish_value(in_data.y, in_data.negate);
    assign y_next     = finish_value(in_data.x, in_data.negate);
    assign valid_next = in_ready ? in_valid : valid_reg;

    // Advance the valid bit
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Hold the result until taken
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            x_reg <= x_next;
            y_reg <= y_next;
        end
    end

    assign vel.valid       = valid_reg;
    assign vel.x_component = x_reg;
    assign vel.y_component = y_reg;

endmodule

`default_nettype wire

>>> rtl/heading_velocity_resolver_core.sv
// Top level of the heading velocity resolver: prep, CORDIC chain, output stage.
//
// Channel | Role   | Payload                                  | Handshake
// cmd     | sink   | direction_forward, speed, heading        | valid/ready
// vel     | source | x_component, y_component                 | valid/ready
//
// One item enters per cycle while the output is not stalled; the path is registered in
// two front stages, one register per CORDIC step and one output register.
// Each stage has its own valid bit and takes a new item when it is empty or
// its successor moves, so bubbles fill in while the output is stalled.
// rst_n clears all valid bits asynchronously; payload registers are not reset.
// The block keeps no state between items.
`timescale 1ns / 1ps
`default_nettype none

module heading_velocity_resolver_core (
    input  wire logic clk,
    input  wire logic rst_n,
    hvr_cmd_if.sink   cmd,
    hvr_vel_if.source vel
);
    import hvr_pkg::*;

    cordic_t chain_data  [0:USED_STAGES];
    logic    chain_valid [0:USED_STAGES];
    logic    chain_ready [0:USED_STAGES];

    // Reduce heading and build start vector
    hvr_prep u_prep (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .out_valid (chain_valid[0]),
        .out_ready (chain_ready[0]),
        .out_data  (chain_data[0])
    );

    // One registered rotation per used CORDIC stage (USED_STAGES arctangent entries)
    for (genvar i = 0; i < USED_STAGES; i++)
    begin : g_stage
        hvr_cordic_stage u_stage (
            .clk       (clk),
            .rst_n     (rst_n),
            .stage_idx (IDX_W'(i)),
            .in_valid  (chain_valid[i]),
            .in_ready  (chain_ready[i]),
            .in_data   (chain_data[i]),
            .out_valid (chain_valid[i+1]),
            .out_ready (chain_ready[i+1]),
            .out_data  (chain_data[i+1])
        );
    end

    // Round, saturate and present the result
    hvr_finish u_finish (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (chain_valid[USED_STAGES]),
        .in_ready (chain_ready[USED_STAGES]),
        .in_data  (chain_data[USED_STAGES]),
        .vel      (vel)
    );

endmodule

`default_nettype wire
